@@ rtl/sm64_pkg.sv @@
// ----------------------------------------------------------------------------
// sm64_pkg
// Shared constants, codes and types for the splitmix64 bounded draw block.
// ----------------------------------------------------------------------------
package sm64_pkg;

    // field widths
    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    // multiplier digit width, bits consumed per cycle
    localparam int unsigned MUL_DIGIT_W = 4;

    // splitmix64 constants
    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;
    localparam int unsigned SHIFT_A = 30;
    localparam int unsigned SHIFT_B = 27;
    localparam int unsigned SHIFT_C = 31;

    // request codes
    typedef enum logic [1:0] {
        ACT_RESTART = 2'd0,
        ACT_DRAW64  = 2'd1,
        ACT_DRAW32  = 2'd2,
        ACT_BOUNDED = 2'd3
    } action_t;

    // result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_LIMIT = 1'b1;

    // configuration register indexes
    localparam logic REG_START_STATE = 1'b0;
    localparam logic REG_START_COUNT = 1'b1;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

@@ rtl/splitmix64_bounded_draw.sv @@
// ----------------------------------------------------------------------------
// splitmix64_bounded_draw
// SplitMix64 generator with draw counter, 64/32-bit draws and unbiased
// bounded draws by rejection, built on serial multiply and remainder units.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser: action; tdata: upper_exclusive
//  m_axis    out  m_axis_tvalid/tready      tuser: status; tdata: value, draws_so_far
//  cfg       in   cfg_we                    cfg_index, cfg_data
//
//  restart or zero limit: straight to the result stage (ST_DONE)
//  64/32-bit draw: one generator step, then two serial multiplies (ST_M1, ST_M2)
//  bounded draw: threshold remainder, draw steps until one is kept, final remainder
//  a rejected bounded draw goes back to the generator step
//  one request at a time; a waiting result holds the sequencer and tready low
//  asynchronous reset clears state, counter and start registers
// ----------------------------------------------------------------------------
module splitmix64_bounded_draw #(
    parameter int unsigned MUL_DIGIT_W = sm64_pkg::MUL_DIGIT_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] upper_exclusive
    input  logic [1:0]   s_axis_tuser,   // [1:0] action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // [63:0] value, [127:64] draws_so_far
    output logic [0:0]   m_axis_tuser,   // [0] status
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TH,
        ST_DRAW,
        ST_M1,
        ST_M2,
        ST_VREM,
        ST_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [63:0]                   gen_reg, gen_next;
    logic [63:0]                   count_reg, count_next;
    logic [63:0]                   start_state_reg, start_state_next;
    logic [63:0]                   start_count_reg, start_count_next;
    logic                          out_valid_reg, out_valid_next;
    sm64_pkg::action_t             action_reg, action_next;
    logic [31:0]                   limit_reg, limit_next;
    logic [31:0]                   thresh_reg, thresh_next;
    logic [63:0]                   value_reg, value_next;
    logic                          status_reg, status_next;
    logic [63:0]                   out_value_reg, out_value_next;
    logic [63:0]                   out_draws_reg, out_draws_next;
    logic                          out_status_reg, out_status_next;

    sm64_pkg::action_t             in_action;
    logic                          s_accept;
    logic                          out_free;
    logic [63:0]                   gen_step;
    logic [63:0]                   mix_a_in;
    logic [63:0]                   mix_b_in;
    logic [63:0]                   fin;
    logic [31:0]                   draw_hi;

    logic                          mul_start;
    logic [63:0]                   mul_a;
    logic [63:0]                   mul_b;
    sm64_pkg::unit_stat_t          mul_stat;
    logic [63:0]                   mul_product;
    logic                          rem_start;
    logic [31:0]                   rem_n;
    logic [31:0]                   rem_d;
    sm64_pkg::unit_stat_t          rem_stat;
    logic [31:0]                   rem_result;

    // input handshake
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_action     = sm64_pkg::action_t'(s_axis_tuser);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // mixing steps around the multiplier
    assign gen_step = gen_reg + sm64_pkg::GOLDEN_STEP;
    assign mix_a_in = gen_step ^ (gen_step >> sm64_pkg::SHIFT_A);
    assign mix_b_in = mul_product ^ (mul_product >> sm64_pkg::SHIFT_B);
    assign fin      = mul_product ^ (mul_product >> sm64_pkg::SHIFT_C);
    assign draw_hi  = fin[63:32];

    // multiplier issue
    assign mul_start = (state_reg == ST_DRAW) || ((state_reg == ST_M1) && mul_stat.done);
    assign mul_a     = (state_reg == ST_DRAW) ? mix_a_in : mix_b_in;
    assign mul_b     = (state_reg == ST_DRAW) ? sm64_pkg::MIX_MUL_A : sm64_pkg::MIX_MUL_B;

    // remainder issue: threshold on accept, final value after a kept draw
    assign rem_start = (s_accept && (in_action == sm64_pkg::ACT_BOUNDED)
                        && (s_axis_tdata != '0))
                    || ((state_reg == ST_M2) && mul_stat.done
                        && (action_reg == sm64_pkg::ACT_BOUNDED)
                        && (draw_hi >= thresh_reg));
    assign rem_n = (state_reg == ST_IDLE) ? (32'd0 - s_axis_tdata) : draw_hi;
    assign rem_d = (state_reg == ST_IDLE) ? s_axis_tdata : limit_reg;

    sm64_mul #(
        .DIGIT_W (MUL_DIGIT_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .stat    (mul_stat),
        .product (mul_product)
    );

    sm64_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .n         (rem_n),
        .d         (rem_d),
        .stat      (rem_stat),
        .remainder (rem_result)
    );

    // request sequencer
    always_comb
    begin
        state_next       = state_reg;
        gen_next         = gen_reg;
        count_next       = count_reg;
        start_state_next = start_state_reg;
        start_count_next = start_count_reg;
        out_valid_next   = out_valid_reg;
        action_next      = action_reg;
        limit_next       = limit_reg;
        thresh_next      = thresh_reg;
        value_next       = value_reg;
        status_next      = status_reg;
        out_value_next   = out_value_reg;
        out_draws_next   = out_draws_reg;
        out_status_next  = out_status_reg;

        // output transaction taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                sm64_pkg::REG_START_STATE: start_state_next = cfg_data;
                sm64_pkg::REG_START_COUNT: start_count_next = cfg_data;
                default:                   start_state_next = start_state_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    action_next = in_action;
                    limit_next  = s_axis_tdata;
                    value_next  = '0;
                    status_next = sm64_pkg::STATUS_OK;
                    unique case (in_action) inside
                        sm64_pkg::ACT_RESTART:
                        begin
                            gen_next   = start_state_reg;
                            count_next = start_count_reg;
                            state_next = ST_DONE;
                        end
                        sm64_pkg::ACT_DRAW64, sm64_pkg::ACT_DRAW32:
                        begin
                            state_next = ST_DRAW;
                        end
                        default:
                        begin
                            if (s_axis_tdata == '0)
                            begin
                                status_next = sm64_pkg::STATUS_BAD_LIMIT;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_TH;
                            end
                        end
                    endcase
                end
            end
            ST_TH:
            begin
                if (rem_stat.done)
                begin
                    thresh_next = rem_result;
                    state_next  = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                gen_next   = gen_step;
                count_next = count_reg + 64'd1;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_M2;
                end
            end
            ST_M2:
            begin
                if (mul_stat.done)
                begin
                    case (action_reg)
                        sm64_pkg::ACT_DRAW64:
                        begin
                            value_next = fin;
                            state_next = ST_DONE;
                        end
                        sm64_pkg::ACT_DRAW32:
                        begin
                            value_next = {32'd0, draw_hi};
                            state_next = ST_DONE;
                        end
                        sm64_pkg::ACT_BOUNDED:
                        begin
                            // rejected draws go round again
                            state_next = (draw_hi < thresh_reg) ? ST_DRAW : ST_VREM;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_VREM:
            begin
                if (rem_stat.done)
                begin
                    value_next = {32'd0, rem_result};
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = value_reg;
                    out_status_next = status_reg;
                    out_draws_next  = count_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            gen_reg         <= '0;
            count_reg       <= '0;
            start_state_reg <= '0;
            start_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            gen_reg         <= gen_next;
            count_reg       <= count_next;
            start_state_reg <= start_state_next;
            start_count_reg <= start_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        limit_reg      <= limit_next;
        thresh_reg     <= thresh_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_draws_reg  <= out_draws_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_draws_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;

    // the two serial units never run together
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && rem_stat.busy))
        else $error("multiplier and remainder unit busy at once");

    // a bad-limit result carries a zero value
    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[0] == sm64_pkg::STATUS_BAD_LIMIT))
        |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("error result with nonzero value");

    // the counter moves only while a transaction is in progress
    a_counter_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && !s_accept) |=> $stable(count_reg))
        else $error("draw counter changed while idle");

    // multiplier results arrive only while the sequencer waits for them
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> ((state_reg == ST_M1) || (state_reg == ST_M2)))
        else $error("multiplier result outside a mixing state");

endmodule

@@ rtl/sm64_mul.sv @@
// ----------------------------------------------------------------------------
// sm64_mul
// Digit-serial 64x64 multiplier, low 64 bits of the product, one digit per
// cycle; done pulses in the cycle after the last digit.
// ----------------------------------------------------------------------------
module sm64_mul #(
    parameter int unsigned DIGIT_W = sm64_pkg::MUL_DIGIT_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sm64_pkg::WORD_W-1:0]   a,
    input  logic [sm64_pkg::WORD_W-1:0]   b,
    output sm64_pkg::unit_stat_t          stat,
    output logic [sm64_pkg::WORD_W-1:0]   product
);

    localparam int unsigned STEPS = sm64_pkg::WORD_W / DIGIT_W;
    localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(STEPS - 1);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [sm64_pkg::WORD_W-1:0]         acc_reg, acc_next;
    logic [sm64_pkg::WORD_W-1:0]         a_reg, a_next;
    logic [sm64_pkg::WORD_W-1:0]         b_reg, b_next;
    logic [sm64_pkg::WORD_W-1:0]         partial;

    // one narrow partial product per cycle, low word only
    always_comb
    begin
        partial = '0;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            if (b_reg[i])
                partial = partial + (a_reg << i);
        end
    end

    // shift-and-add step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST_CNT;
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + partial;
            a_next   = a_reg << DIGIT_W;
            b_next   = b_reg >> DIGIT_W;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

@@ rtl/sm64_rem.sv @@
// ----------------------------------------------------------------------------
// sm64_rem
// Bit-serial restoring remainder unit, 32-bit dividend and nonzero divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sm64_rem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sm64_pkg::HALF_W-1:0]   n,
    input  logic [sm64_pkg::HALF_W-1:0]   d,
    output sm64_pkg::unit_stat_t          stat,
    output logic [sm64_pkg::HALF_W-1:0]   remainder
);

    localparam int unsigned CNT_W = $clog2(sm64_pkg::HALF_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(sm64_pkg::HALF_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [sm64_pkg::HALF_W-1:0]   rem_reg, rem_next;
    logic [sm64_pkg::HALF_W-1:0]   n_reg, n_next;
    logic [sm64_pkg::HALF_W-1:0]   d_reg, d_next;
    logic [sm64_pkg::HALF_W:0]     trial;
    logic [sm64_pkg::HALF_W:0]     diff;
    logic                          fits;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, n_reg[sm64_pkg::HALF_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = (trial >= {1'b0, d_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = LAST_CNT;
            rem_next  = '0;
            n_next    = n;
            d_next    = d;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[sm64_pkg::HALF_W-1:0] : trial[sm64_pkg::HALF_W-1:0];
            n_next   = n_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

@@ test/splitmix64_draw_checker.sv @@
// ----------------------------------------------------------------------------
// splitmix64_draw_checker
// Watches the request, result and register write channels of the splitmix64
// bounded draw block. Keeps its own copy of the generator state, the draw
// counter and the start registers, predicts one result per accepted request
// and compares every accepted result, field by field, with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module splitmix64_draw_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] upper_exclusive
    input  logic [1:0]   s_axis_tuser,   // [1:0] action
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,   // [63:0] value, [127:64] draws_so_far
    input  logic [0:0]   m_axis_tuser,   // [0] status
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data,
    output int           mismatches,
    output int           pending
);

    typedef struct {
        logic [63:0] value;
        logic        status;
        logic [63:0] draws;
    } draw_result_t;

    // shadow copy of the block state
    logic [63:0] start_state_r;
    logic [63:0] start_count_r;
    logic [63:0] gen_state;
    logic [63:0] draw_count;

    draw_result_t expected_q[$];

    // one generator step: advance state and counter, return the mixed word
    function automatic logic [63:0] mix_step();
        logic [63:0] z;
        gen_state  = gen_state + sm64_pkg::GOLDEN_STEP;
        z          = gen_state;
        z          = (z ^ (z >> sm64_pkg::SHIFT_A)) * sm64_pkg::MIX_MUL_A;
        z          = (z ^ (z >> sm64_pkg::SHIFT_B)) * sm64_pkg::MIX_MUL_B;
        draw_count = draw_count + 64'd1;
        return z ^ (z >> sm64_pkg::SHIFT_C);
    endfunction

    // result of one request, updating the shadow state
    function automatic draw_result_t predict_request(input sm64_pkg::action_t act,
                                                     input logic [31:0] limit);
        draw_result_t r;
        logic [31:0]  threshold;
        logic [63:0]  word;
        logic [31:0]  v;
        r.value  = '0;
        r.status = sm64_pkg::STATUS_OK;
        case (act)
            sm64_pkg::ACT_RESTART:
            begin
                gen_state  = start_state_r;
                draw_count = start_count_r;
            end
            sm64_pkg::ACT_DRAW64:
            begin
                r.value = mix_step();
            end
            sm64_pkg::ACT_DRAW32:
            begin
                word    = mix_step();
                r.value = {32'd0, word[63:32]};
            end
            default:
            begin
                if (limit == 32'd0)
                begin
                    r.status = sm64_pkg::STATUS_BAD_LIMIT;
                end
                else
                begin
                    // reject draws below (2^32 - limit) mod limit
                    threshold = (32'd0 - limit) % limit;
                    word      = mix_step();
                    v         = word[63:32];
                    while (v < threshold)
                    begin
                        word = mix_step();
                        v    = word[63:32];
                    end
                    r.value = {32'd0, v % limit};
                end
            end
        endcase
        r.draws = draw_count;
        return r;
    endfunction

    // register writes, request transactions and result transactions
    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t want;
        draw_result_t got;
        if (!rst_n)
        begin
            start_state_r = '0;
            start_count_r = '0;
            gen_state     = '0;
            draw_count    = '0;
            expected_q.delete();
            mismatches    = 0;
            pending       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sm64_pkg::REG_START_STATE)
                    start_state_r = cfg_data;
                else
                    start_count_r = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(predict_request(sm64_pkg::action_t'(s_axis_tuser),
                                                     s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value  = m_axis_tdata[63:0];
                got.draws  = m_axis_tdata[127:64];
                got.status = m_axis_tuser[0];
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: %h %0d %h",
                                 $realtime, got.value, got.status, got.draws);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.value !== want.value || got.status !== want.status ||
                        got.draws !== want.draws)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("    value  exp %h got %h", want.value, got.value);
                            $display("    status exp %0d got %0d", want.status, got.status);
                            $display("    draws  exp %h got %h", want.draws, got.draws);
                        end
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

@@ test/tb_splitmix64_bounded_draw.sv @@
// ----------------------------------------------------------------------------
// tb_splitmix64_bounded_draw
// Drives the splitmix64 bounded draw block with a directed set of requests
// (limit extremes, zero limit, high rejection limits, counter wrap) and then
// random requests under three idle patterns, including a long receiver
// hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_splitmix64_bounded_draw;

    localparam int HOLDOFF_CYCLES = 600;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata  = '0;   // [31:0] upper_exclusive
    logic [1:0]   s_axis_tuser  = '0;   // [1:0] action
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;         // [63:0] value, [127:64] draws_so_far
    logic [0:0]   m_axis_tuser;         // [0] status
    logic         cfg_we        = 1'b0;
    logic         cfg_index     = 1'b0;
    logic [63:0]  cfg_data      = '0;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_rx        = 1'b0;
    int  mismatches;
    int  pending;
    int  n_req[4];
    int  n_zero_limit   = 0;
    int  n_loads        = 0;

    always #5 clk = ~clk;

    splitmix64_bounded_draw dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    splitmix64_draw_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // result side: random stalls, forced low during a hold-off
    always @(posedge clk)
    begin
        m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("splitmix64_bounded_draw verification failed");
        $finish;
    end

    // one request transaction, with an optional random gap in front
    task automatic send_request(input sm64_pkg::action_t act, input logic [31:0] limit);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= limit;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_req[act]++;
        if (act == sm64_pkg::ACT_BOUNDED && limit == 32'd0)
            n_zero_limit++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // write both start registers, block idle
    task automatic load_start(input logic [63:0] st, input logic [63:0] cnt);
        cfg_we    <= 1'b1;
        cfg_index <= sm64_pkg::REG_START_STATE;
        cfg_data  <= st;
        @(posedge clk);
        cfg_index <= sm64_pkg::REG_START_COUNT;
        cfg_data  <= cnt;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_loads++;
    endtask

    // bounded draws lean toward small limits and high rejection limits
    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1, 2:    return $urandom_range(1, 16);
            3:       return 32'd1 << $urandom_range(0, 31);
            4:       return 32'h8000_0000 + $urandom_range(1, 4096);
            5:       return 32'hffff_ffff - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic sm64_pkg::action_t pick_action();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return sm64_pkg::ACT_RESTART;
        else if (r < 7)
            return sm64_pkg::ACT_DRAW64;
        else if (r < 12)
            return sm64_pkg::ACT_DRAW32;
        else
            return sm64_pkg::ACT_BOUNDED;
    endfunction

    task automatic run_random(input int count);
        sm64_pkg::action_t act;
        repeat (count)
        begin
            act = pick_action();
            send_request(act, (act == sm64_pkg::ACT_BOUNDED) ? pick_limit() : $urandom);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles 35 of 100, receiver 74 of 100
        send_idle_pct  = 35;
        recv_stall_pct = 74;

        // directed: from reset state, limit extremes and zero limit
        send_request(sm64_pkg::ACT_DRAW64, 32'd0);
        send_request(sm64_pkg::ACT_DRAW32, 32'hffff_ffff);
        send_request(sm64_pkg::ACT_BOUNDED, 32'd1);
        send_request(sm64_pkg::ACT_BOUNDED, 32'd0);
        send_request(sm64_pkg::ACT_BOUNDED, 32'hffff_ffff);
        send_request(sm64_pkg::ACT_BOUNDED, 32'h8000_0001);
        send_request(sm64_pkg::ACT_BOUNDED, 32'h8000_0000);
        send_request(sm64_pkg::ACT_BOUNDED, 32'd3);
        send_request(sm64_pkg::ACT_RESTART, 32'd0);
        drain();

        // counter wrap from an all-ones start state and a count just below all-ones
        load_start('1, 64'hffff_ffff_ffff_fffe);
        send_request(sm64_pkg::ACT_RESTART, 32'hffff_ffff);
        send_request(sm64_pkg::ACT_DRAW64, 32'd0);
        send_request(sm64_pkg::ACT_DRAW64, 32'd0);
        send_request(sm64_pkg::ACT_DRAW32, 32'd0);
        send_request(sm64_pkg::ACT_BOUNDED, 32'd0);
        send_request(sm64_pkg::ACT_BOUNDED, 32'd7);
        drain();

        // state that steps onto zero, then a high rejection limit
        load_start(64'd0 - sm64_pkg::GOLDEN_STEP, 64'h8000_0000_0000_0000);
        send_request(sm64_pkg::ACT_RESTART, 32'd0);
        send_request(sm64_pkg::ACT_DRAW64, 32'd0);
        send_request(sm64_pkg::ACT_BOUNDED, 32'h8000_0001);
        drain();

        // random, first idle pattern
        load_start({$urandom, $urandom}, {$urandom, $urandom});
        send_request(sm64_pkg::ACT_RESTART, $urandom);
        run_random(230);
        drain();

        // random, idle pattern swapped
        send_idle_pct  = 74;
        recv_stall_pct = 35;
        load_start('0, '0);
        send_request(sm64_pkg::ACT_RESTART, $urandom);
        run_random(230);
        drain();

        // random, no idling, with a long receiver hold-off at the start
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_start({$urandom, $urandom}, 64'hffff_ffff_ffff_fffc);
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                hold_rx <= 1'b0;
            end
        join_none
        send_request(sm64_pkg::ACT_RESTART, $urandom);
        run_random(240);
        drain();
        repeat (50) @(posedge clk);

        $display("covered %0d requests: %0d restart, %0d draw64, %0d draw32",
                 n_req[0] + n_req[1] + n_req[2] + n_req[3],
                 n_req[sm64_pkg::ACT_RESTART], n_req[sm64_pkg::ACT_DRAW64],
                 n_req[sm64_pkg::ACT_DRAW32]);
        $display("%0d bounded (%0d zero limit), %0d start loads, %0d-cycle hold-off",
                 n_req[sm64_pkg::ACT_BOUNDED], n_zero_limit, n_loads, HOLDOFF_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("splitmix64_bounded_draw verification clean");
        else
            $display("splitmix64_bounded_draw verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sm64_pkg.sv
rtl/sm64_mul.sv
rtl/sm64_rem.sv
rtl/splitmix64_bounded_draw.sv
test/splitmix64_draw_checker.sv
test/tb_splitmix64_bounded_draw.sv
